// File: rtl/hqg_pkg.sv
// Package: shared constants, types and helpers of the Householder Q generation block.
package hqg_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int MEM_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int Q_W      = 48;
  localparam int CFG_W    = 7;
  localparam int IDX_W    = 6;
  localparam int ACC_W    = Q_W + ROW_W;
  localparam int PADDR_W  = 4;

  localparam logic [Q_W-1:0] Q_ONE = 48'h0001_0000_0000;
  localparam logic [Q_W-1:0] Q_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [Q_W-1:0] Q_MIN = 48'h8000_0000_0000;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_SAT     = 2'd2;

  localparam logic [1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [1:0] REG_COL_COUNT = 2'd1;
  localparam logic [1:0] REG_REF_COUNT = 2'd2;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_TAU     = 2'd1,
    CMD_COMPUTE = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_ID, S_TAU, S_TAU2, S_COL,
    S_DOT_RA, S_DOT_RB, S_DOT_MS, S_DOT_MW, S_DOT_FIN, S_FIN_W,
    S_UPD_RA, S_UPD_RB, S_UPD_MS, S_UPD_MW,
    S_SC_RA, S_SC_MS, S_SC_MW, S_DIAG, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    WS_DATA, WS_ONE, WS_ZERO, WS_MUL, WS_SUM, WS_DIAG
  } wsel_t;

  typedef enum logic {MA_A, MA_S} asel_t;
  typedef enum logic [1:0] {MB_RD, MB_A12, MB_ACC} bsel_t;
  typedef enum logic {OS_FLAG, OS_INVALID} osel_t;

  typedef struct packed {
    logic [CFG_W-1:0] row_count;
    logic [CFG_W-1:0] col_count;
    logic [CFG_W-1:0] reflector_count;
  } cfg_t;

  typedef struct packed {
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    wsel_t             wsel;
    logic              tau_we;
    logic [COL_W-1:0]  tau_addr;
    logic              ld_tau;
    logic              ld_a;
    logic              ld_b;
    logic              ld_a12;
    logic              mul_start;
    asel_t             asel;
    bsel_t             bsel;
    logic              acc_clr;
    logic              acc_add;
    logic              sat_clr;
    logic              out_load;
    logic              out_rd;
    osel_t             osel;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic mul_done;
    logic slot_free;
  } dp_stat_t;

  function automatic logic [ADDR_W-1:0] mk_addr(input logic [CFG_W-1:0] r,
                                                 input logic [CFG_W-1:0] c);
    return {r[ROW_W-1:0], c[COL_W-1:0]};
  endfunction

endpackage

// File: rtl/hqg_mul.sv
// Sequential Q16.32 multiplier: four 24x24 partial products, rounding and saturation.
module hqg_mul
  import hqg_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [Q_W-1:0] a,
  input  logic [Q_W-1:0] b,
  output logic           busy,
  output logic           done,
  output logic [Q_W-1:0] res,
  output logic           sat
);

  logic [Q_W-1:0]   ua_r, ub_r, res_r;
  logic             neg_r, busy_r, fin_r, done_r, sat_r;
  logic [1:0]       cnt_r;
  logic [2*Q_W-1:0] prod_r;
  logic [23:0]      pa, pb;
  logic [47:0]      pp;
  logic [2*Q_W-1:0] ppx, rnd;
  logic [63:0]      q;
  logic [Q_W-1:0]   res_nxt;
  logic             sat_nxt;

  assign pa = cnt_r[1] ? ua_r[47:24] : ua_r[23:0];
  assign pb = cnt_r[0] ? ub_r[47:24] : ub_r[23:0];
  assign pp = pa * pb;

  always_comb begin
    case (cnt_r)
      2'd0:    ppx = {48'b0, pp};
      2'd3:    ppx = {pp, 48'b0};
      default: ppx = {24'b0, pp, 24'b0};
    endcase
  end

  assign rnd = prod_r + 96'h8000_0000;
  assign q   = rnd[95:32];

  always_comb begin
    sat_nxt = 1'b0;
    if (neg_r) begin
      if (q > 64'h0000_8000_0000_0000) begin
        res_nxt = Q_MIN;
        sat_nxt = 1'b1;
      end else begin
        res_nxt = ~q[Q_W-1:0] + 48'd1;
      end
    end else begin
      if (q > 64'h0000_7FFF_FFFF_FFFF) begin
        res_nxt = Q_MAX;
        sat_nxt = 1'b1;
      end else begin
        res_nxt = q[Q_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      done_r <= fin_r;
      fin_r  <= busy_r && (cnt_r == 2'd3);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 2'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ua_r   <= a[Q_W-1] ? (~a + 48'd1) : a;
      ub_r   <= b[Q_W-1] ? (~b + 48'd1) : b;
      neg_r  <= a[Q_W-1] ^ b[Q_W-1];
      prod_r <= '0;
    end else if (busy_r) begin
      prod_r <= prod_r + ppx;
    end
    if (fin_r) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign busy = busy_r || fin_r || done_r;
  assign done = done_r;
  assign res  = res_r;
  assign sat  = sat_r;

endmodule

// File: rtl/hqg_dp.sv
// Datapath: matrix and tau memories, multiplier, accumulator, saturation flag, result register.
module hqg_dp
  import hqg_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  dp_cmd_t        cmd,
  output dp_stat_t       stat,
  input  logic [Q_W-1:0] in_data_value,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [Q_W-1:0] out_read_value,
  output logic [1:0]     out_status
);

  logic [Q_W-1:0]   mem [MEM_DEPTH];
  logic [Q_W-1:0]   tau_mem [MAX_COLS];
  logic [Q_W-1:0]   rdata_r, tau_rdata_r;
  logic [Q_W-1:0]   tau_r, s_r, a_r, b_r, a12_r;
  logic [ACC_W-1:0] acc_r;
  logic             flag_r;
  logic             out_valid_r;
  logic [Q_W-1:0]   out_read_r;
  logic [1:0]       out_status_r;

  logic [Q_W-1:0]   wdata, mul_a, mul_b, mul_res, acc_sat, sum_sat, diag_sat, s_nxt;
  logic             mul_busy, mul_done, mul_sat;
  logic             acc_ovf, sum_ovf, diag_ovf, s_ovf;
  logic [Q_W:0]     sum, diag;

  hqg_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .res   (mul_res),
    .sat   (mul_sat)
  );

  assign acc_ovf = !((&acc_r[ACC_W-1:Q_W-1]) || !(|acc_r[ACC_W-1:Q_W-1]));
  assign acc_sat = acc_ovf ? (acc_r[ACC_W-1] ? Q_MIN : Q_MAX) : acc_r[Q_W-1:0];

  assign sum     = {b_r[Q_W-1], b_r} + {mul_res[Q_W-1], mul_res};
  assign sum_ovf = sum[Q_W] ^ sum[Q_W-1];
  assign sum_sat = sum_ovf ? (sum[Q_W] ? Q_MIN : Q_MAX) : sum[Q_W-1:0];

  assign diag     = {1'b0, Q_ONE} - {tau_r[Q_W-1], tau_r};
  assign diag_ovf = diag[Q_W] ^ diag[Q_W-1];
  assign diag_sat = diag_ovf ? (diag[Q_W] ? Q_MIN : Q_MAX) : diag[Q_W-1:0];

  assign s_ovf = (tau_rdata_r == Q_MIN);
  assign s_nxt = s_ovf ? Q_MAX : (~tau_rdata_r + 48'd1);

  always_comb begin
    case (cmd.asel)
      MA_S:    mul_a = s_r;
      default: mul_a = a_r;
    endcase
    case (cmd.bsel)
      MB_A12:  mul_b = a12_r;
      MB_ACC:  mul_b = acc_sat;
      default: mul_b = rdata_r;
    endcase
    case (cmd.wsel)
      WS_DATA: wdata = in_data_value;
      WS_ONE:  wdata = Q_ONE;
      WS_MUL:  wdata = mul_res;
      WS_SUM:  wdata = sum_sat;
      WS_DIAG: wdata = diag_sat;
      default: wdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[cmd.mem_addr] <= wdata;
    end
    rdata_r <= mem[cmd.mem_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.tau_we) begin
      tau_mem[cmd.tau_addr] <= in_data_value;
    end
    tau_rdata_r <= tau_mem[cmd.tau_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_tau) begin
      tau_r <= tau_rdata_r;
      s_r   <= s_nxt;
    end
    if (cmd.ld_a) begin
      a_r <= rdata_r;
    end
    if (cmd.ld_b) begin
      b_r <= rdata_r;
    end
    if (cmd.ld_a12) begin
      a12_r <= mul_res;
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + {{ROW_W{mul_res[Q_W-1]}}, mul_res};
    end
    if (cmd.out_load) begin
      out_read_r <= cmd.out_rd ? rdata_r : '0;
      case (cmd.osel)
        OS_INVALID: out_status_r <= ST_INVALID;
        default:    out_status_r <= flag_r ? ST_SAT : ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.sat_clr) begin
        flag_r <= 1'b0;
      end else if ((mul_done && mul_sat) || (cmd.ld_tau && s_ovf) ||
                   (cmd.mul_start && cmd.bsel == MB_ACC && acc_ovf) ||
                   (cmd.mem_we && cmd.wsel == WS_SUM && sum_ovf) ||
                   (cmd.mem_we && cmd.wsel == WS_DIAG && diag_ovf)) begin
        flag_r <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.mul_busy  = mul_busy;
  assign stat.mul_done  = mul_done;
  assign stat.slot_free = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_r;
  assign out_status     = out_status_r;

endmodule

// File: rtl/hqg_ctrl.sv
// Controller: request decode and the loop sequencer of the compute pass.
module hqg_ctrl
  import hqg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_cmd,
  input  logic [IDX_W-1:0] in_row_index,
  input  logic [IDX_W-1:0] in_col_index,
  input  dp_stat_t         stat,
  output dp_cmd_t          cmd
);

  state_t           state_r, state_nxt;
  logic [CFG_W-1:0] i_r, i_nxt, j_r, j_nxt, c_r, c_nxt;
  logic             rd_ok_r, rd_ok_nxt;
  logic             accept, sizes_ok, elem_ok, tau_ok;
  logic [CFG_W-1:0] m, n, k, in_row, in_col, jp1;
  cmd_t             op;

  assign m      = cfg.row_count;
  assign n      = cfg.col_count;
  assign k      = cfg.reflector_count;
  assign in_row = CFG_W'(in_row_index);
  assign in_col = CFG_W'(in_col_index);
  assign jp1    = j_r + CFG_W'(1);
  assign op     = cmd_t'(in_cmd);

  assign in_ready = (state_r == S_IDLE) && stat.slot_free;
  assign accept   = in_valid && in_ready;
  assign sizes_ok = (m != '0) && (n != '0) && (int'(m) <= MAX_ROWS) &&
                    (int'(n) <= MAX_COLS) && (k <= n) && (n <= m);
  assign elem_ok  = (int'(in_row) < MAX_ROWS) && (int'(in_col) < MAX_COLS);
  assign tau_ok   = int'(in_row) < MAX_COLS;

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    c_nxt     = c_r;
    rd_ok_nxt = rd_ok_r;
    case (state_r)
      S_IDLE: begin
        if (accept && op == CMD_READ) begin
          state_nxt = S_RD;
          rd_ok_nxt = elem_ok;
        end else if (accept && op == CMD_COMPUTE && sizes_ok) begin
          state_nxt = S_ID;
          j_nxt     = k;
          i_nxt     = '0;
        end
      end
      S_RD: state_nxt = S_IDLE;
      S_ID: begin
        if (j_r < n) begin
          if (i_r == m - CFG_W'(1)) begin
            i_nxt = '0;
            j_nxt = jp1;
          end else begin
            i_nxt = i_r + CFG_W'(1);
          end
        end else if (k == '0) begin
          state_nxt = S_DONE;
        end else begin
          j_nxt     = k - CFG_W'(1);
          state_nxt = S_TAU;
        end
      end
      S_TAU: state_nxt = S_TAU2;
      S_TAU2: begin
        c_nxt     = jp1;
        state_nxt = S_COL;
      end
      S_COL: begin
        i_nxt     = jp1;
        state_nxt = (c_r < n) ? S_DOT_RA : S_SC_RA;
      end
      S_DOT_RA: state_nxt = (i_r < m) ? S_DOT_RB : S_DOT_FIN;
      S_DOT_RB: state_nxt = S_DOT_MS;
      S_DOT_MS: state_nxt = S_DOT_MW;
      S_DOT_MW: begin
        if (stat.mul_done) begin
          i_nxt     = i_r + CFG_W'(1);
          state_nxt = S_DOT_RA;
        end
      end
      S_DOT_FIN: state_nxt = S_FIN_W;
      S_FIN_W: begin
        if (stat.mul_done) begin
          i_nxt     = jp1;
          state_nxt = S_UPD_RA;
        end
      end
      S_UPD_RA: begin
        if (i_r < m) begin
          state_nxt = S_UPD_RB;
        end else begin
          c_nxt     = c_r + CFG_W'(1);
          state_nxt = S_COL;
        end
      end
      S_UPD_RB: state_nxt = S_UPD_MS;
      S_UPD_MS: state_nxt = S_UPD_MW;
      S_UPD_MW: begin
        if (stat.mul_done) begin
          i_nxt     = i_r + CFG_W'(1);
          state_nxt = S_UPD_RA;
        end
      end
      S_SC_RA: state_nxt = (i_r < m) ? S_SC_MS : S_DIAG;
      S_SC_MS: state_nxt = S_SC_MW;
      S_SC_MW: begin
        if (stat.mul_done) begin
          i_nxt     = i_r + CFG_W'(1);
          state_nxt = S_SC_RA;
        end
      end
      S_DIAG: begin
        if (j_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          j_nxt     = j_r - CFG_W'(1);
          state_nxt = S_TAU;
        end
      end
      S_DONE: begin
        if (stat.slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.wsel      = WS_ZERO;
    cmd.asel      = MA_A;
    cmd.bsel      = MB_RD;
    cmd.osel      = OS_FLAG;
    cmd.mem_addr  = mk_addr(i_r, j_r);
    cmd.tau_addr  = j_r[COL_W-1:0];
    case (state_r)
      S_IDLE: begin
        cmd.mem_addr = mk_addr(in_row, in_col);
        cmd.tau_addr = in_row[COL_W-1:0];
        if (accept) begin
          case (op)
            CMD_WRITE: begin
              cmd.mem_we   = elem_ok;
              cmd.wsel     = WS_DATA;
              cmd.out_load = 1'b1;
            end
            CMD_TAU: begin
              cmd.tau_we   = tau_ok;
              cmd.out_load = 1'b1;
            end
            CMD_COMPUTE: begin
              if (sizes_ok) begin
                cmd.sat_clr = 1'b1;
              end else begin
                cmd.out_load = 1'b1;
                cmd.osel     = OS_INVALID;
              end
            end
            default: cmd.out_load = 1'b0;
          endcase
        end
      end
      S_RD: begin
        cmd.out_load = 1'b1;
        cmd.out_rd   = rd_ok_r;
      end
      S_ID: begin
        cmd.mem_we = j_r < n;
        cmd.wsel   = (i_r == j_r) ? WS_ONE : WS_ZERO;
      end
      S_TAU2:   cmd.ld_tau = 1'b1;
      S_COL:    cmd.acc_clr = c_r < n;
      S_DOT_RB: begin
        cmd.mem_addr = mk_addr(i_r, c_r);
        cmd.ld_a     = 1'b1;
      end
      S_DOT_MS: cmd.mul_start = 1'b1;
      S_DOT_MW: cmd.acc_add = stat.mul_done;
      S_DOT_FIN: begin
        cmd.mul_start = 1'b1;
        cmd.asel      = MA_S;
        cmd.bsel      = MB_ACC;
      end
      S_FIN_W: begin
        cmd.mem_addr = mk_addr(j_r, c_r);
        cmd.mem_we   = stat.mul_done;
        cmd.ld_a12   = stat.mul_done;
        cmd.wsel     = WS_MUL;
      end
      S_UPD_RB: begin
        cmd.mem_addr = mk_addr(i_r, c_r);
        cmd.ld_a     = 1'b1;
      end
      S_UPD_MS: begin
        cmd.mul_start = 1'b1;
        cmd.bsel      = MB_A12;
        cmd.ld_b      = 1'b1;
      end
      S_UPD_MW: begin
        cmd.mem_addr = mk_addr(i_r, c_r);
        cmd.mem_we   = stat.mul_done;
        cmd.wsel     = WS_SUM;
      end
      S_SC_MS: begin
        cmd.mul_start = 1'b1;
        cmd.asel      = MA_S;
      end
      S_SC_MW: begin
        cmd.mem_we = stat.mul_done;
        cmd.wsel   = WS_MUL;
      end
      S_DIAG: begin
        cmd.mem_addr = mk_addr(j_r, j_r);
        cmd.mem_we   = 1'b1;
        cmd.wsel     = WS_DIAG;
      end
      S_DONE: cmd.out_load = stat.slot_free;
      default: cmd.out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      c_r     <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      c_r     <= c_nxt;
      rd_ok_r <= rd_ok_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_start |-> !stat.mul_busy) else $error("multiplier started while busy");
  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.slot_free) else $error("result loaded into a full slot");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_IDLE) else $error("request taken outside idle");
  a_diag_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIAG |-> j_r < n) else $error("diagonal write out of range");
`endif

endmodule

// File: rtl/householder_q_generation.sv
// Top level: APB register file, controller and datapath of the Householder Q generation block.
//
// Requests enter on the in_ channel (valid/ready): write element, write tau, compute
// or read element. Each request yields exactly one result on the out_ channel
// (read_value, status). Element and tau writes load their result as the request is
// taken; a read first passes through the registered read of the matrix memory.
// Compute first writes the identity columns k..n-1, then per reflector walks every
// trailing column through a dot pass and an update pass, scales the reflector column
// and writes its diagonal element 1-tau. Each row of a dot or update pass issues two
// memory reads, the multiplier start and a wait on the shared sequential multiplier
// (four 24x24 partial products).
// Sizes m, n and k are set through the APB port at byte addresses 0, 4 and 8. The user
// must write them only while the block is idle; the block does not enforce this.
// Reset clears the control state and the saturation flag and sets m=64, n=64, k=0;
// matrix and tau contents stay undefined until written.
// A result waits in the output register while out_ready is low; the next request
// is taken only once that register is free or being emptied.
module householder_q_generation
  import hqg_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic [IDX_W-1:0]   in_row_index,
  input  logic [IDX_W-1:0]   in_col_index,
  input  logic [Q_W-1:0]     in_data_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [Q_W-1:0]     out_read_value,
  output logic [1:0]         out_status
);

  cfg_t     cfg_r;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_count       <= CFG_W'(64);
      cfg_r.col_count       <= CFG_W'(64);
      cfg_r.reflector_count <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ROW_COUNT: cfg_r.row_count       <= pwdata[CFG_W-1:0];
        REG_COL_COUNT: cfg_r.col_count       <= pwdata[CFG_W-1:0];
        REG_REF_COUNT: cfg_r.reflector_count <= pwdata[CFG_W-1:0];
        default:       cfg_r.row_count       <= cfg_r.row_count;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ROW_COUNT: prdata = 32'(cfg_r.row_count);
      REG_COL_COUNT: prdata = 32'(cfg_r.col_count);
      REG_REF_COUNT: prdata = 32'(cfg_r.reflector_count);
      default:       prdata = '0;
    endcase
  end

  hqg_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_row_index (in_row_index),
    .in_col_index (in_col_index),
    .stat         (stat),
    .cmd          (cmd)
  );

  hqg_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_data_value  (in_data_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_value (out_read_value),
    .out_status     (out_status)
  );

endmodule

// File: bench/testbench.sv
// Testbench for householder_q_generation: self-checking scoreboard with randomized requests.
`timescale 1ns / 1ps

module testbench;
  import hqg_pkg::*;

  typedef logic signed [Q_W-1:0] q_t;

  localparam int WATCHDOG_LIMIT = 600000;
  localparam int ITEM_TARGET    = 1400;

  class q_factor_scoreboard;
    q_t          mat [MAX_ROWS][MAX_COLS];
    q_t          tau [MAX_COLS];
    bit          sat;
    int unsigned m, n, k;
    q_t          exp_value [$];
    logic [1:0]  exp_status [$];
    int          errors;

    function new();
      sat = 0;
      m = 64;
      n = 64;
      k = 0;
      errors = 0;
    endfunction

    function void set_size(logic [1:0] idx, int unsigned v);
      case (idx)
        REG_ROW_COUNT: m = v & 7'h7F;
        REG_COL_COUNT: n = v & 7'h7F;
        REG_REF_COUNT: k = v & 7'h7F;
        default: ;
      endcase
    endfunction

    function q_t clamp(longint v);
      if (v > longint'(48'sh7FFF_FFFF_FFFF)) begin
        sat = 1;
        return Q_MAX;
      end
      if (v < -longint'(64'h8000_0000_0000)) begin
        sat = 1;
        return Q_MIN;
      end
      return v[Q_W-1:0];
    endfunction

    function q_t qmul(q_t a, q_t b);
      logic [Q_W-1:0] ua, ub;
      logic [95:0]    p, q;
      bit             neg;
      neg = a[Q_W-1] != b[Q_W-1];
      ua = a[Q_W-1] ? (~a + 1'b1) : a;
      ub = b[Q_W-1] ? (~b + 1'b1) : b;
      p = 96'(ua) * 96'(ub);
      q = (p + 96'h8000_0000) >> 32;
      if (neg) begin
        if (q > 96'h8000_0000_0000) begin
          sat = 1;
          return Q_MIN;
        end
        return -q[Q_W-1:0];
      end
      if (q > 96'h7FFF_FFFF_FFFF) begin
        sat = 1;
        return Q_MAX;
      end
      return q[Q_W-1:0];
    endfunction

    function logic [1:0] form_q();
      int     i, j, c;
      longint acc;
      q_t     s, a12;
      if (m < 1 || n < 1 || m > MAX_ROWS || n > MAX_COLS || k > n || n > m)
        return ST_INVALID;
      sat = 0;
      for (j = k; j < n; j++) begin
        for (i = 0; i < m; i++) mat[i][j] = '0;
        mat[j][j] = Q_ONE;
      end
      for (j = k - 1; j >= 0; j--) begin
        s = clamp(-longint'(tau[j]));
        for (c = j + 1; c < n; c++) begin
          acc = 0;
          for (i = j + 1; i < m; i++) acc += longint'(qmul(mat[i][j], mat[i][c]));
          a12 = qmul(s, clamp(acc));
          mat[j][c] = a12;
          for (i = j + 1; i < m; i++)
            mat[i][c] = clamp(longint'(mat[i][c]) + longint'(qmul(mat[i][j], a12)));
        end
        for (i = j + 1; i < m; i++) mat[i][j] = qmul(s, mat[i][j]);
        mat[j][j] = clamp(longint'(Q_ONE) - longint'(tau[j]));
      end
      return sat ? ST_SAT : ST_OK;
    endfunction

    function void note_request(cmd_t cmd, logic [5:0] r, logic [5:0] c, q_t v);
      q_t         rd;
      logic [1:0] st;
      rd = '0;
      if (cmd == CMD_COMPUTE) begin
        st = form_q();
      end else begin
        case (cmd)
          CMD_WRITE: mat[r][c] = v;
          CMD_TAU:   tau[r] = v;
          CMD_READ:  rd = mat[r][c];
          default: ;
        endcase
        st = sat ? ST_SAT : ST_OK;
      end
      exp_value.push_back(rd);
      exp_status.push_back(st);
    endfunction

    function void check_result(q_t rv, logic [1:0] st);
      q_t         ev;
      logic [1:0] es;
      if (exp_value.size() == 0) begin
        $display("%0t: unexpected result read_value=%h status=%0d", $time, rv, st);
        errors++;
        return;
      end
      ev = exp_value.pop_front();
      es = exp_status.pop_front();
      if (rv !== ev) begin
        $display("%0t: read_value mismatch expected=%h actual=%h", $time, ev, rv);
        errors++;
      end
      if (st !== es) begin
        $display("%0t: status mismatch expected=%0d actual=%0d", $time, es, st);
        errors++;
      end
    endfunction

    function int pending();
      return exp_value.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;
  logic             in_valid, in_ready;
  logic [1:0]       in_cmd;
  logic [IDX_W-1:0] in_row_index, in_col_index;
  logic [Q_W-1:0]   in_data_value;
  logic             out_valid, out_ready;
  logic [Q_W-1:0]   out_read_value;
  logic [1:0]       out_status;

  q_factor_scoreboard sb;
  int  sent_count;
  int  result_count;
  int  idle_cycles;
  int  in_gap_max;
  int  out_gap_max;
  bit  held_off;
  bit  written [MAX_ROWS][MAX_COLS];
  int  written_list [$];

  householder_q_generation DUT (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .in_row_index(in_row_index), .in_col_index(in_col_index),
    .in_data_value(in_data_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_read_value(out_read_value), .out_status(out_status)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic q_t rand_q();
    logic [63:0] x;
    longint      y;
    case ($urandom_range(0, 15))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3, 4: begin
        x = {$urandom, $urandom};
        return x[Q_W-1:0];
      end
      default: begin
        y = $urandom;
        y = y * 4 - (64'sd1 <<< 33);
        return y[Q_W-1:0];
      end
    endcase
  endfunction

  task automatic send(cmd_t cmd, logic [5:0] r, logic [5:0] c, q_t v);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_row_index  <= r;
    in_col_index  <= c;
    in_data_value <= v;
    do @(posedge clk); while (!in_ready);
    sb.note_request(cmd, r, c, v);
    sent_count++;
    if (cmd == CMD_WRITE && !written[r][c]) begin
      written[r][c] = 1;
      written_list.push_back(int'({r, c}));
    end
  endtask

  task automatic write_elem(logic [5:0] r, logic [5:0] c, q_t v);
    send(CMD_WRITE, r, c, v);
  endtask

  task automatic read_any();
    logic [11:0] a;
    a = 12'(written_list[$urandom_range(0, written_list.size() - 1)]);
    send(CMD_READ, a[11:6], a[5:0], rand_q());
  endtask

  task automatic compute_q();
    int i, j;
    send(CMD_COMPUTE, 6'($urandom), 6'($urandom), rand_q());
    if (sb.m >= 1 && sb.n >= 1 && sb.m <= MAX_ROWS && sb.n <= MAX_COLS &&
        sb.k <= sb.n && sb.n <= sb.m)
      for (j = sb.k; j < sb.n; j++)
        for (i = 0; i < sb.m; i++)
          if (!written[i][j]) begin
            written[i][j] = 1;
            written_list.push_back(int'({6'(i), 6'(j)}));
          end
  endtask

  task automatic noise();
    case ($urandom_range(0, 2))
      0: write_elem(6'($urandom), 6'($urandom), rand_q());
      1: send(CMD_TAU, 6'($urandom), 6'($urandom), rand_q());
      default: read_any();
    endcase
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, int unsigned v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx) << 2;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_size(idx, v);
  endtask

  task automatic set_sizes(int unsigned m, int unsigned n, int unsigned k);
    wait_idle();
    cfg_write(REG_ROW_COUNT, m);
    cfg_write(REG_COL_COUNT, n);
    cfg_write(REG_REF_COUNT, k);
  endtask

  initial begin
    rst_n         = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid      = 1'b0;
    in_cmd        = CMD_WRITE;
    in_row_index  = '0;
    in_col_index  = '0;
    in_data_value = '0;
    out_ready     = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      if (result_count >= 300 && !held_off) begin
        gap = 400;
        held_off = 1;
      end else begin
        gap = $urandom_range(0, out_gap_max);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_read_value, out_status);
      result_count++;
    end
  end

  initial begin
    int unsigned m, n, k;
    int          i, j, sel;
    bit          sizes_ok;
    sb = new();
    sent_count = 0;
    in_gap_max = 10;
    out_gap_max = 10;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_elem(0, 0, Q_MAX);
    write_elem(63, 63, Q_MIN);
    write_elem(63, 0, '0);
    write_elem(0, 63, '1);
    send(CMD_READ, 0, 0, '0);
    send(CMD_READ, 63, 63, Q_MAX);
    send(CMD_TAU, 63, 0, Q_MAX);
    send(CMD_TAU, 0, 63, Q_MIN);
    compute_q();
    send(CMD_READ, 63, 63, '0);
    send(CMD_READ, 0, 63, '0);
    send(CMD_READ, 63, 0, '0);
    set_sizes(2, 2, 1);
    write_elem(1, 0, Q_MAX);
    send(CMD_TAU, 0, 0, Q_MIN);
    compute_q();
    send(CMD_READ, 1, 0, '0);
    send(CMD_READ, 0, 0, '0);
    set_sizes(1, 64, 0);
    compute_q();
    set_sizes(0, 1, 0);
    compute_q();
    set_sizes(8, 4, 64);
    compute_q();
    send(CMD_READ, 1, 1, '0);

    while (sent_count < ITEM_TARGET) begin
      sel = $urandom_range(0, 15);
      if (sel == 0) begin
        n = $urandom_range(1, 64);
        k = $urandom_range(n + 1, 127);
        m = $urandom_range(0, 127);
      end else if (sel == 1) begin
        m = $urandom_range(9, 16);
        n = $urandom_range(1, 8);
        k = $urandom_range(0, n);
      end else begin
        m = $urandom_range(1, 6);
        n = $urandom_range(1, m);
        k = $urandom_range(0, n);
      end
      sizes_ok = sel != 0;
      set_sizes(m, n, k);
      in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 10;
      out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
      if (sizes_ok) begin
        for (i = 0; i < m; i++)
          for (j = 0; j < n; j++) begin
            write_elem(6'(i), 6'(j), rand_q());
            if ($urandom_range(0, 5) == 0) noise();
          end
        for (j = 0; j < k; j++) send(CMD_TAU, 6'(j), 6'($urandom), rand_q());
      end else begin
        repeat ($urandom_range(1, 4)) noise();
      end
      compute_q();
      repeat ($urandom_range(2, 8)) read_any();
    end

    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/hqg_pkg.sv
rtl/hqg_mul.sv
rtl/hqg_dp.sv
rtl/hqg_ctrl.sv
rtl/householder_q_generation.sv
bench/testbench.sv
